// ----- rtl/core/binary_grid_majority_smooth_unit_defines.svh -----
// ----------------------------------------------------------------------------
// binary grid majority smooth unit - assertion macros
// shared concurrent assertion forms, clocked on clk, off while arst_n is low
// ----------------------------------------------------------------------------
`ifndef BINARY_GRID_MAJORITY_SMOOTH_UNIT_DEFINES_SVH
`define BINARY_GRID_MAJORITY_SMOOTH_UNIT_DEFINES_SVH

// property must hold at every edge out of reset
`define BGMS_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// condition must never be seen out of reset
`define BGMS_ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

// ----- rtl/core/bgms_pkg.sv -----
// ----------------------------------------------------------------------------
// bgms_pkg
// shared constants and types of the binary grid majority smooth unit
// ----------------------------------------------------------------------------
package bgms_pkg;

	localparam int unsigned MAX_WIDTH_DEF  = 32;
	localparam int unsigned WIDTH_BITS     = 6;
	localparam int unsigned HEIGHT_BITS    = 16;
	localparam int unsigned CFG_INDEX_BITS = 2;
	localparam int unsigned CFG_DATA_BITS  = 16;

	localparam logic [CFG_INDEX_BITS-1:0] REG_GRID_WIDTH  = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_GRID_HEIGHT = 2'd1;

	localparam logic [WIDTH_BITS-1:0]  WIDTH_RESET  = 6'd32;
	localparam logic [HEIGHT_BITS-1:0] HEIGHT_RESET = 16'd32;

	// which sides of the 3x3 neighborhood lie inside the grid
	typedef struct packed {
		logic top;
		logic bottom;
		logic left;
		logic right;
	} bound_mask_t;

endpackage

// ----- rtl/core/bgms_window.sv -----
// ----------------------------------------------------------------------------
// bgms_window
// two line delays, the 3x3 window registers and the majority vote
// ----------------------------------------------------------------------------
module bgms_window #(
	parameter int unsigned MAX_WIDTH = bgms_pkg::MAX_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            adv,
	input  logic                            cell_bit,
	input  logic [bgms_pkg::WIDTH_BITS-1:0] width,
	input  bgms_pkg::bound_mask_t           mask,
	output logic                            wall
);

	localparam int unsigned IDX_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

	logic [MAX_WIDTH-1:0] line_mid_q;
	logic [MAX_WIDTH-1:0] line_top_q;
	logic [2:0]           win_t_q;
	logic [2:0]           win_m_q;
	logic [2:0]           win_b_q;

	logic [IDX_W-1:0] tap;
	logic             mid_in;
	logic             top_in;
	logic [2:0]       win_t_n;
	logic [2:0]       win_m_n;
	logic [2:0]       win_b_n;
	logic [8:0]       cells;
	logic [8:0]       en;
	logic [2:0]       row_en;
	logic [2:0]       col_en;
	logic [3:0]       walls;
	logic [3:0]       total;

	assign tap    = IDX_W'(width - 6'd1);
	assign mid_in = line_mid_q[tap];
	assign top_in = line_top_q[tap];

	// bit 2 newest column (c+1), bit 0 oldest (c-1)
	assign win_b_n = {cell_bit, win_b_q[2:1]};
	assign win_m_n = {mid_in, win_m_q[2:1]};
	assign win_t_n = {top_in, win_t_q[2:1]};

	always_ff @(posedge clk) begin
		if (adv) begin
			line_mid_q[0] <= cell_bit;
			line_top_q[0] <= mid_in;
			for (int i = 1; i < MAX_WIDTH; i++) begin
				line_mid_q[i] <= line_mid_q[i-1];
				line_top_q[i] <= line_top_q[i-1];
			end
			win_b_q <= win_b_n;
			win_m_q <= win_m_n;
			win_t_q <= win_t_n;
		end
	end

	always_comb begin
		row_en = {mask.top, 1'b1, mask.bottom};
		col_en = {mask.right, 1'b1, mask.left};
		cells  = {win_t_n, win_m_n, win_b_n};
		en     = {row_en[2] ? col_en : 3'b000,
		          row_en[1] ? col_en : 3'b000,
		          row_en[0] ? col_en : 3'b000};
		walls  = 4'($countones(cells & en));
		total  = 4'($countones(en));
		wall   = {walls, 1'b0} > {1'b0, total};
	end

endmodule

// ----- rtl/core/binary_grid_majority_smooth_unit.sv -----
// ----------------------------------------------------------------------------
// binary_grid_majority_smooth_unit
// one 3x3 majority smoothing pass over a raster stream of wall/floor cells
// ----------------------------------------------------------------------------
// channel  dir  handshake            payload
// s_*      in   s_tvalid/s_tready    tdata[0] cell_is_wall
// m_*      out  m_tvalid/m_tready    tdata[0] smoothed_is_wall, tlast run_last,
//                                    tuser[0] frame_last
// cfg_*    in   cfg_valid/cfg_ready  cfg_index register, cfg_data value
//
// one cell per clock while s_tready is high; a result leaves the clock after
// the cell that completes its neighborhood, width+1 cells behind the input
// (width clamped to 1..MAX_WIDTH); after the final cell of a frame the line
// delays take width+1 more zero cells to drain the last row, with s_tready low
// s_tready follows m_tready through the single output register
// arst_n clears counters and handshake state; line delays are not cleared
// ----------------------------------------------------------------------------
`include "binary_grid_majority_smooth_unit_defines.svh"

module binary_grid_majority_smooth_unit #(
	parameter int unsigned MAX_WIDTH = bgms_pkg::MAX_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [7:0]                          s_tdata,   // [0] cell_is_wall
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [7:0]                          m_tdata,   // [0] smoothed_is_wall
	output logic                                m_tlast,
	output logic [0:0]                          m_tuser,   // [0] frame_last
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [bgms_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [bgms_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

	localparam int unsigned LAG_W = $clog2(MAX_WIDTH + 2);
	localparam logic [bgms_pkg::WIDTH_BITS-1:0] MAX_W = bgms_pkg::WIDTH_BITS'(MAX_WIDTH);

	logic [bgms_pkg::WIDTH_BITS-1:0]  width_q;
	logic [bgms_pkg::HEIGHT_BITS-1:0] height_q;
	logic [bgms_pkg::WIDTH_BITS-1:0]  in_col_q;
	logic [bgms_pkg::HEIGHT_BITS-1:0] in_row_q;
	logic [bgms_pkg::WIDTH_BITS-1:0]  out_col_q;
	logic [bgms_pkg::HEIGHT_BITS-1:0] out_row_q;
	logic [LAG_W-1:0]                 lag_q;
	logic [LAG_W-1:0]                 flush_cnt_q;
	logic                             flush_q;
	logic                             out_valid_q;
	logic                             out_wall_q;
	logic                             out_run_last_q;
	logic                             out_frame_last_q;

	logic [bgms_pkg::WIDTH_BITS-1:0]  w_eff;
	logic [bgms_pkg::HEIGHT_BITS-1:0] h_eff;
	logic [LAG_W-1:0]                 lag_target;
	logic                             out_space;
	logic                             accept;
	logic                             adv;
	logic                             emit;
	logic                             last_in;
	logic                             frame_emit;
	logic                             run_last_n;
	logic                             cfg_hit;
	logic                             cell_bit;
	logic                             wall;
	bgms_pkg::bound_mask_t            mask;

	always_comb begin
		if (width_q == '0) begin
			w_eff = 6'd1;
		end else if (width_q > MAX_W) begin
			w_eff = MAX_W;
		end else begin
			w_eff = width_q;
		end
		h_eff = (height_q == '0) ? 16'd1 : height_q;
	end

	assign lag_target = LAG_W'({1'b0, w_eff} + 7'd1);
	assign out_space  = !out_valid_q || m_tready;
	assign s_tready   = !flush_q && out_space;
	assign accept     = s_tvalid && s_tready;
	assign adv        = accept || (flush_q && out_space);
	assign emit       = adv && (lag_q == lag_target);
	assign last_in    = (in_col_q >= w_eff - 6'd1) && (in_row_q >= h_eff - 16'd1);
	assign frame_emit = flush_q && (flush_cnt_q == LAG_W'(1));
	assign run_last_n = flush_q ? frame_emit : !last_in;
	assign cell_bit   = accept ? s_tdata[0] : 1'b0;
	assign cfg_ready  = 1'b1;
	assign cfg_hit    = cfg_valid && ((cfg_index == bgms_pkg::REG_GRID_WIDTH) ||
	                                  (cfg_index == bgms_pkg::REG_GRID_HEIGHT));

	always_comb begin
		mask.top    = (out_row_q != '0);
		mask.bottom = (out_row_q != h_eff - 16'd1);
		mask.left   = (out_col_q != '0);
		mask.right  = (out_col_q != w_eff - 6'd1);
	end

	bgms_window #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_window (
		.clk     (clk),
		.adv     (adv),
		.cell_bit(cell_bit),
		.width   (w_eff),
		.mask    (mask),
		.wall    (wall)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= bgms_pkg::WIDTH_RESET;
			height_q <= bgms_pkg::HEIGHT_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				bgms_pkg::REG_GRID_WIDTH: begin
					width_q <= cfg_data[bgms_pkg::WIDTH_BITS-1:0];
				end
				bgms_pkg::REG_GRID_HEIGHT: begin
					height_q <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	// input position, fill lag and drain sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q    <= '0;
			in_row_q    <= '0;
			lag_q       <= '0;
			flush_q     <= 1'b0;
			flush_cnt_q <= '0;
		end else if (cfg_hit) begin
			in_col_q    <= '0;
			in_row_q    <= '0;
			lag_q       <= '0;
			flush_q     <= 1'b0;
			flush_cnt_q <= '0;
		end else if (adv) begin
			if (lag_q != lag_target) begin
				lag_q <= lag_q + LAG_W'(1);
			end
			if (flush_q) begin
				flush_cnt_q <= flush_cnt_q - LAG_W'(1);
				if (frame_emit) begin
					flush_q <= 1'b0;
					lag_q   <= '0;
				end
			end else if (last_in) begin
				in_col_q    <= '0;
				in_row_q    <= '0;
				flush_q     <= 1'b1;
				flush_cnt_q <= lag_target;
			end else if (in_col_q >= w_eff - 6'd1) begin
				in_col_q <= '0;
				in_row_q <= in_row_q + 16'd1;
			end else begin
				in_col_q <= in_col_q + 6'd1;
			end
		end
	end

	// position of the next result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (cfg_hit || (emit && frame_emit)) begin
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (emit) begin
			if (out_col_q >= w_eff - 6'd1) begin
				out_col_q <= '0;
				out_row_q <= out_row_q + 16'd1;
			end else begin
				out_col_q <= out_col_q + 6'd1;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_wall_q       <= wall;
			out_run_last_q   <= run_last_n;
			out_frame_last_q <= frame_emit;
		end
	end

	assign m_tvalid   = out_valid_q;
	assign m_tdata    = {7'd0, out_wall_q};
	assign m_tlast    = out_run_last_q;
	assign m_tuser[0] = out_frame_last_q;

	`BGMS_ASSERT_NEVER(a_no_input_in_drain, flush_q && s_tready, "input taken while draining")
	`BGMS_ASSERT_NEVER(a_no_overwrite, emit && out_valid_q && !m_tready, "held result overwritten")
	`BGMS_ASSERT(a_frame_wraps, (emit && frame_emit) |=> (out_row_q == '0 && out_col_q == '0), "result position not rewound after frame")
	`BGMS_ASSERT(a_lag_bound, lag_q <= lag_target, "fill lag beyond one row and one cell")
	`BGMS_ASSERT(a_drain_count, flush_q |-> (flush_cnt_q != '0 && flush_cnt_q <= lag_target), "drain count out of range")

endmodule

// ----- verif/tb_binary_grid_majority_smooth_unit.sv -----
// ----------------------------------------------------------------------------
// tb_binary_grid_majority_smooth_unit
// self-checking bench for the 3x3 majority smoothing pass; a queue-fed driver
// streams raster frames and register writes, a line-store predictor computes
// every smoothed cell, and the monitor checks each output transfer in order
// under several sender and receiver idle mixes
// ----------------------------------------------------------------------------
module tb_binary_grid_majority_smooth_unit;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned LINE_DEPTH    = bgms_pkg::MAX_WIDTH_DEF;
	localparam int unsigned SETTLE_CYCLES = 48;
	localparam int unsigned QUIET_LIMIT   = 5000;
	localparam int unsigned PHASE_CELLS   = 32;

	// indexes with no register behind them
	localparam logic [bgms_pkg::CFG_INDEX_BITS-1:0] REG_SPARE_A = 2'd2;
	localparam logic [bgms_pkg::CFG_INDEX_BITS-1:0] REG_SPARE_B = 2'd3;

	typedef enum logic [1:0] {ITEM_CELL, ITEM_REG, ITEM_HOLD} stim_kind_t;
	typedef enum logic [1:0] {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

	typedef struct {
		stim_kind_t                          kind;
		logic [bgms_pkg::CFG_INDEX_BITS-1:0] index;
		logic [bgms_pkg::CFG_DATA_BITS-1:0]  value;
		logic                                wall;
	} stim_item_t;

	typedef struct packed {
		logic [7:0] data;
		logic       run_last;
		logic       frame_last;
	} smooth_result_t;

	logic                                clk       = 1'b0;
	logic                                arst_n    = 1'b0;
	logic                                s_tvalid  = 1'b0;
	logic                                s_tready;
	logic [7:0]                          s_tdata   = '0;   // [0] cell_is_wall
	logic                                m_tvalid;
	logic                                m_tready  = 1'b0;
	logic [7:0]                          m_tdata;          // [0] smoothed_is_wall
	logic                                m_tlast;          // run_last
	logic [0:0]                          m_tuser;          // [0] frame_last
	logic                                cfg_valid = 1'b0;
	logic                                cfg_ready;
	logic [bgms_pkg::CFG_INDEX_BITS-1:0] cfg_index = bgms_pkg::REG_GRID_WIDTH;
	logic [bgms_pkg::CFG_DATA_BITS-1:0]  cfg_data  = '0;

	stim_item_t     stim_q[$];
	smooth_result_t smoothed_q[$];

	// predictor state
	logic             line_rows [4][LINE_DEPTH];
	logic [5:0]       grid_w_reg = bgms_pkg::WIDTH_RESET;
	logic [15:0]      grid_h_reg = bgms_pkg::HEIGHT_RESET;
	int unsigned      cell_col   = 0;
	int unsigned      cell_row   = 0;

	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned err_count = 0;
	int unsigned cells_sent = 0;
	int unsigned reg_writes = 0;
	int unsigned results_seen = 0;
	int unsigned frames_seen = 0;
	int unsigned quiet_cycles = 0;

	binary_grid_majority_smooth_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #1 clk = ~clk;

	function automatic int unsigned cols_eff();
		if (grid_w_reg == 0)
			return 1;
		if (grid_w_reg > LINE_DEPTH)
			return LINE_DEPTH;
		return grid_w_reg;
	endfunction

	function automatic int unsigned rows_eff();
		return (grid_h_reg == 0) ? 1 : grid_h_reg;
	endfunction

	function automatic logic wall_majority(int unsigned pos, int unsigned w, int unsigned h);
		int r;
		int c;
		int walls;
		int floors;
		r = pos / w;
		c = pos % w;
		walls = 0;
		floors = 0;
		for (int dr = -1; dr <= 1; dr++) begin
			for (int dc = -1; dc <= 1; dc++) begin
				if (r + dr >= 0 && r + dr < int'(h) && c + dc >= 0 && c + dc < int'(w)) begin
					if (line_rows[(r + dr) & 3][c + dc])
						walls++;
					else
						floors++;
				end
			end
		end
		return walls > floors;
	endfunction

	function automatic void apply_reg(logic [bgms_pkg::CFG_INDEX_BITS-1:0] idx,
			logic [bgms_pkg::CFG_DATA_BITS-1:0] value);
		if (idx == bgms_pkg::REG_GRID_WIDTH) begin
			grid_w_reg = value[5:0];
		end else if (idx == bgms_pkg::REG_GRID_HEIGHT) begin
			grid_h_reg = value;
		end else begin
			return;
		end
		cell_col = 0;
		cell_row = 0;
	endfunction

	function automatic void predict_cell(logic wall);
		int unsigned w;
		int unsigned h;
		int unsigned pos;
		int unsigned last_pos;
		int unsigned flush_from;
		smooth_result_t res;
		w = cols_eff();
		h = rows_eff();
		if (cell_col >= w)
			cell_col = 0;
		if (cell_row >= h)
			cell_row = 0;
		line_rows[cell_row & 3][cell_col] = wall;
		pos = cell_row * w + cell_col;
		last_pos = h * w - 1;
		if (pos == last_pos) begin
			flush_from = (pos >= w + 1) ? pos - w - 1 : 0;
			for (int unsigned q = flush_from; q <= last_pos; q++) begin
				res.data = {7'd0, wall_majority(q, w, h)};
				res.run_last = (q == last_pos);
				res.frame_last = (q == last_pos);
				smoothed_q.push_back(res);
			end
			cell_col = 0;
			cell_row = 0;
		end else begin
			if (pos >= w + 1) begin
				res.data = {7'd0, wall_majority(pos - w - 1, w, h)};
				res.run_last = 1'b1;
				res.frame_last = 1'b0;
				smoothed_q.push_back(res);
			end
			if (cell_col + 1 >= w) begin
				cell_col = 0;
				cell_row = (cell_row + 1) & 16'hFFFF;
			end else begin
				cell_col++;
			end
		end
	endfunction

	function automatic void note_error(string msg);
		if (err_count < 10)
			$display("%s", msg);
		err_count++;
	endfunction

	// driver: one cell or register write in flight at a time
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			cfg_valid <= 1'b0;
			cfg_index <= bgms_pkg::REG_GRID_WIDTH;
			cfg_data <= '0;
		end else begin
			logic cell_fire;
			logic reg_fire;
			logic nxt_s_valid;
			logic nxt_c_valid;
			stim_item_t head;
			cell_fire = s_tvalid && s_tready;
			reg_fire = cfg_valid && cfg_ready;
			if (cell_fire) begin
				predict_cell(s_tdata[0]);
				cells_sent++;
			end
			if (reg_fire) begin
				apply_reg(cfg_index, cfg_data);
				reg_writes++;
			end
			nxt_s_valid = s_tvalid && !cell_fire;
			nxt_c_valid = cfg_valid && !reg_fire;
			if (!nxt_s_valid && !nxt_c_valid && stim_q.size() != 0) begin
				head = stim_q[0];
				case (head.kind)
					ITEM_HOLD: begin
						if (smoothed_q.size() == 0)
							stim_q.delete(0);
					end
					ITEM_REG: begin
						cfg_index <= head.index;
						cfg_data <= head.value;
						nxt_c_valid = 1'b1;
						stim_q.delete(0);
					end
					default: begin
						if ($urandom_range(99) >= send_idle_pct) begin
							s_tdata <= {7'd0, head.wall};
							nxt_s_valid = 1'b1;
							stim_q.delete(0);
						end
					end
				endcase
			end
			s_tvalid <= nxt_s_valid;
			cfg_valid <= nxt_c_valid;
		end
	end

	// monitor: checks every output transfer against the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			smooth_result_t want;
			smooth_result_t got;
			if (m_tvalid && m_tready) begin
				got = {m_tdata, m_tlast, m_tuser[0]};
				if (smoothed_q.size() == 0) begin
					note_error($sformatf("unexpected result data=%h last=%b frame_last=%b",
						got.data, got.run_last, got.frame_last));
				end else begin
					want = smoothed_q.pop_front();
					if (got !== want)
						note_error($sformatf({"result %0d: expected data=%h last=%b ",
							"frame_last=%b, got data=%h last=%b frame_last=%b"},
							results_seen, want.data, want.run_last, want.frame_last,
							got.data, got.run_last, got.frame_last));
				end
				results_seen++;
				if (m_tuser[0])
					frames_seen++;
			end
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("watchdog: no transfer for %0d cycles", quiet_cycles);
				$display("binary_grid_majority_smooth_unit regression: fail");
				$finish;
			end
		end
	end

	task automatic set_idle(idle_mode_t mode);
		send_idle_pct = (mode == IDLE_SEND) ? 53 : (mode == IDLE_BOTH) ? 36 : 0;
		recv_stall_pct = (mode == IDLE_RECV) ? 53 : (mode == IDLE_BOTH) ? 36 : 0;
	endtask

	task automatic queue_reg(logic [bgms_pkg::CFG_INDEX_BITS-1:0] idx,
			logic [bgms_pkg::CFG_DATA_BITS-1:0] value);
		stim_item_t it;
		it.kind = ITEM_REG;
		it.index = idx;
		it.value = value;
		it.wall = 1'b0;
		stim_q.push_back(it);
	endtask

	task automatic queue_cell(logic wall);
		stim_item_t it;
		it.kind = ITEM_CELL;
		it.index = bgms_pkg::REG_GRID_WIDTH;
		it.value = '0;
		it.wall = wall;
		stim_q.push_back(it);
	endtask

	// wall density in percent; a hold makes the sender wait for every result
	task automatic queue_cells(int unsigned n, int unsigned density, int hold_at);
		stim_item_t it;
		for (int unsigned i = 0; i < n; i++) begin
			if (int'(i) == hold_at) begin
				it.kind = ITEM_HOLD;
				it.index = bgms_pkg::REG_GRID_WIDTH;
				it.value = '0;
				it.wall = 1'b0;
				stim_q.push_back(it);
			end
			queue_cell($urandom_range(99) < density);
		end
	endtask

	task automatic wait_idle();
		do
			@(negedge clk);
		while (stim_q.size() != 0 || s_tvalid || cfg_valid || smoothed_q.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	function automatic int unsigned pick_density();
		if ($urandom_range(3) == 0)
			return $urandom_range(1) ? 100 : 0;
		return $urandom_range(20, 80);
	endfunction

	initial begin
		logic [bgms_pkg::CFG_DATA_BITS-1:0] wval;
		logic [bgms_pkg::CFG_DATA_BITS-1:0] hval;
		int unsigned w_cells;
		int unsigned h_rows;
		int unsigned frame_cells;
		int unsigned sent;
		int hold_at;

		for (int r = 0; r < 4; r++)
			for (int c = 0; c < LINE_DEPTH; c++)
				line_rows[r][c] = 1'b0;

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// zero width and height act as a single-cell frame
		set_idle(IDLE_NONE);
		queue_reg(bgms_pkg::REG_GRID_WIDTH, 16'h0000);
		queue_reg(bgms_pkg::REG_GRID_HEIGHT, 16'h0000);
		queue_cell(1'b1);
		queue_cell(1'b0);
		wait_idle();

		// 2x2 with two walls: every window ties and goes to floor
		queue_reg(bgms_pkg::REG_GRID_WIDTH, 16'h0002);
		queue_reg(bgms_pkg::REG_GRID_HEIGHT, 16'h0002);
		queue_cell(1'b1);
		queue_cell(1'b0);
		queue_cell(1'b0);
		queue_cell(1'b1);
		wait_idle();

		// tallest frame, left unfinished; spare indexes must not restart it
		queue_reg(bgms_pkg::REG_GRID_WIDTH, 16'hFFC4);
		queue_reg(bgms_pkg::REG_GRID_HEIGHT, 16'hFFFF);
		queue_cells(6, 50, -1);
		wait_idle();
		queue_reg(REG_SPARE_A, 16'hFFFF);
		queue_reg(REG_SPARE_B, 16'h5A5A);
		queue_cells(3, 50, -1);
		wait_idle();

		// a new write restarts the frame mid-way
		queue_reg(bgms_pkg::REG_GRID_WIDTH, 16'h0003);
		queue_reg(bgms_pkg::REG_GRID_HEIGHT, 16'h0002);
		queue_cell(1'b1);
		queue_cell(1'b1);
		queue_cell(1'b0);
		queue_cell(1'b1);
		queue_cell(1'b0);
		queue_cell(1'b0);
		wait_idle();

		for (int ph = 0; ph < 8; ph++) begin
			set_idle(idle_mode_t'(ph % 4));
			wval = 16'($urandom) & 16'hFFC0;
			case (ph)
				1: begin
					wval |= 16'd62;
					hval = 16'd2;
				end
				3: begin
					wval |= 16'd1;
					hval = 16'($urandom_range(2, 9));
				end
				5: begin
					wval |= 16'd63;
					hval = 16'd1;
				end
				default: begin
					wval |= 16'($urandom_range(1, 8));
					hval = 16'($urandom_range(1, 6));
				end
			endcase
			if ($urandom_range(1)) begin
				queue_reg(bgms_pkg::REG_GRID_HEIGHT, hval);
				queue_reg(bgms_pkg::REG_GRID_WIDTH, wval);
			end else begin
				queue_reg(bgms_pkg::REG_GRID_WIDTH, wval);
				queue_reg(bgms_pkg::REG_GRID_HEIGHT, hval);
			end
			w_cells = (wval[5:0] == 0) ? 1 : (wval[5:0] > LINE_DEPTH) ? LINE_DEPTH : wval[5:0];
			h_rows = (hval == 0) ? 1 : hval;
			frame_cells = w_cells * h_rows;
			hold_at = $urandom_range(frame_cells - 1);
			sent = 0;
			while (sent < PHASE_CELLS) begin
				queue_cells(frame_cells, pick_density(), hold_at);
				hold_at = -1;
				sent += frame_cells;
			end
			// abandoned frame, cleared by the next phase's writes
			if ((ph == 2 || ph == 6) && frame_cells > 1)
				queue_cells($urandom_range(1, frame_cells - 1), pick_density(), -1);
			wait_idle();
		end

		$display("sent %0d cells and %0d register writes across 4 idle mixes and sizes 1..32",
			cells_sent, reg_writes);
		$display("checked %0d smoothed results, %0d frame ends, %0d mismatches",
			results_seen, frames_seen, err_count);
		if (err_count == 0)
			$display("binary_grid_majority_smooth_unit regression: pass");
		else
			$display("binary_grid_majority_smooth_unit regression: fail");
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/bgms_pkg.sv
rtl/core/bgms_window.sv
rtl/core/binary_grid_majority_smooth_unit.sv
verif/tb_binary_grid_majority_smooth_unit.sv
